/* rtl/dppc_pkg.sv */
// Shared types, constants and saturating helpers for the dual PID position controller.
// Used by dppc_pid_lane and dual_pid_position_controller_core; depends on nothing.
`default_nettype none
package dppc_pkg;

  localparam int POS_W     = 32;
  localparam int DIFF_W    = 33;
  localparam int SUM_W     = 48;
  localparam int GAIN_W    = 24;
  localparam int THR_W     = 16;
  localparam int DRIVE_W   = 15;
  localparam int STALL_W   = 3;
  localparam int FRAC_BITS = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_TARGET  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_TARGET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_P_GAIN       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_I_GAIN       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_D_GAIN       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_THR   = 3'd5;

  // load strobes for the arithmetic stages behind the state stage
  typedef struct packed {
    logic ld2;
    logic ld3;
    logic ld4;
  } pipe_ctl_t;

  // target minus position, saturated to 32 bits
  function automatic logic signed [POS_W-1:0] err_sat(input logic signed [POS_W-1:0] tgt,
                                                     input logic signed [POS_W-1:0] pos);
    logic signed [POS_W:0] d;
    d = {tgt[POS_W-1], tgt} - {pos[POS_W-1], pos};
    if (d[POS_W] != d[POS_W-1]) begin
      err_sat = d[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      err_sat = d[POS_W-1:0];
    end
  endfunction

  // integral plus error, saturated to 48 bits
  function automatic logic signed [SUM_W-1:0] sum_sat(input logic signed [SUM_W-1:0] sum,
                                                     input logic signed [POS_W-1:0] err);
    logic signed [SUM_W:0] s;
    s = {sum[SUM_W-1], sum} + {{(SUM_W-POS_W+1){err[POS_W-1]}}, err};
    if (s[SUM_W] != s[SUM_W-1]) begin
      sum_sat = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_sat = s[SUM_W-1:0];
    end
  endfunction

  function automatic logic below_thr(input logic signed [POS_W-1:0] err,
                                     input logic [THR_W-1:0] thr);
    logic [POS_W-1:0] mag;
    mag = err[POS_W-1] ? POS_W'(-err) : err;
    below_thr = mag < {{(POS_W-THR_W){1'b0}}, thr};
  endfunction

endpackage
`default_nettype wire

/* rtl/dppc_pid_lane.sv */
// One side's PID arithmetic: gain products, exact sum, truncation and drive clamp.
// Three register stages; uses dppc_pkg for widths and the stage load struct.
`default_nettype none
module dppc_pid_lane #(
  parameter int DRIVE_LIMIT = 12000
) (
  input  wire                                   clk,
  input  wire dppc_pkg::pipe_ctl_t              ctl,
  input  wire logic signed [dppc_pkg::POS_W-1:0]  err_i,
  input  wire logic signed [dppc_pkg::DIFF_W-1:0] diff_i,
  input  wire logic signed [dppc_pkg::SUM_W-1:0]  sum_i,
  input  wire logic signed [dppc_pkg::GAIN_W-1:0] p_gain,
  input  wire logic signed [dppc_pkg::GAIN_W-1:0] i_gain,
  input  wire logic signed [dppc_pkg::GAIN_W-1:0] d_gain,
  input  wire logic                               brake_i,
  output logic        [dppc_pkg::DRIVE_W-1:0]     drive_o
);

  localparam int HALF_W = dppc_pkg::SUM_W / 2;
  localparam int PE_W   = dppc_pkg::POS_W + dppc_pkg::GAIN_W;
  localparam int DE_W   = dppc_pkg::DIFF_W + dppc_pkg::GAIN_W;
  localparam int IL_W   = HALF_W + 1 + dppc_pkg::GAIN_W;
  localparam int IH_W   = HALF_W + dppc_pkg::GAIN_W;
  localparam int TOT_W  = IH_W + HALF_W + 1;
  localparam int Q_W    = TOT_W - dppc_pkg::FRAC_BITS;

  logic signed [PE_W-1:0]   pe_r, pe_nxt;
  logic signed [DE_W-1:0]   de_r, de_nxt;
  logic signed [IL_W-1:0]   il_r, il_nxt;
  logic signed [IH_W-1:0]   ih_r, ih_nxt;
  logic signed [HALF_W:0]   sum_lo;
  logic signed [HALF_W-1:0] sum_hi;
  logic signed [TOT_W-1:0]  tot_r, tot_nxt;
  logic signed [TOT_W-1:0]  biased;
  logic signed [Q_W-1:0]    quot, lim, clamped;
  logic [dppc_pkg::DRIVE_W-1:0] drive_r, drive_nxt;

  // integral term split in two halves so each multiplier stays 25x24
  assign sum_lo = {1'b0, sum_i[HALF_W-1:0]};
  assign sum_hi = sum_i[dppc_pkg::SUM_W-1:HALF_W];

  always_comb begin
    pe_nxt = err_i * p_gain;
    de_nxt = diff_i * d_gain;
    il_nxt = sum_lo * i_gain;
    ih_nxt = sum_hi * i_gain;
  end

  always_comb begin
    tot_nxt = TOT_W'(pe_r) + TOT_W'(de_r) + TOT_W'(il_r)
            + TOT_W'($signed({ih_r, {HALF_W{1'b0}}}));
  end

  // shift with a bias on negative sums gives truncation toward zero
  always_comb begin
    biased  = tot_r + (tot_r[TOT_W-1] ? TOT_W'((1 << dppc_pkg::FRAC_BITS) - 1) : TOT_W'(0));
    quot    = biased[TOT_W-1:dppc_pkg::FRAC_BITS];
    lim     = Q_W'(DRIVE_LIMIT);
    if (quot > lim) begin
      clamped = lim;
    end else if (quot < -lim) begin
      clamped = -lim;
    end else begin
      clamped = quot;
    end
    drive_nxt = brake_i ? '0 : clamped[dppc_pkg::DRIVE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.ld2) begin
      pe_r <= pe_nxt;
      de_r <= de_nxt;
      il_r <= il_nxt;
      ih_r <= ih_nxt;
    end
    if (ctl.ld3) begin
      tot_r <= tot_nxt;
    end
    if (ctl.ld4) begin
      drive_r <= drive_nxt;
    end
  end

  assign drive_o = drive_r;

endmodule
`default_nettype wire

/* rtl/dual_pid_position_controller_core.sv */
// Top level of the dual PID position controller: config registers, tick state, pipeline control.
// Depends on dppc_pkg and dppc_pid_lane.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+----------------------------------------------
//  in_      | sink      | in_tvalid/in_tready | tdata: left/right position; tuser: restart
//  out_     | source    | out_tvalid/tready   | tdata: left/right drive; tuser: brake, settled
//  cfg_     | sink      | cfg_valid/cfg_ready | cfg_index, cfg_data (register write)
//
// One tick per clock while out_tready stays high; each request passes stages 0 through 4.
// Integral, previous errors and stall count close their loop in a single stage (stage 1).
// Stages hold independently, so bubbles collapse and input is taken while a result waits.
// Synchronous active-low reset clears valids, tick state and config registers; no clearing pass.
// cfg_ready is always high; writes are expected only while the pipeline is empty.
`default_nettype none
module dual_pid_position_controller_core #(
  parameter int DRIVE_LIMIT = 12000,
  parameter int STALL_LIMIT = 5
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // [31:0] left_position, [63:32] right_position
  input  wire logic [0:0]  in_tuser,   // [0] restart
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [14:0] left_drive, [29:15] right_drive, [31:30] zero
  output logic [1:0]       out_tuser,  // [0] brake, [1] settled
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [dppc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int PW = dppc_pkg::POS_W;
  localparam int SW = dppc_pkg::SUM_W;
  localparam int GW = dppc_pkg::GAIN_W;
  localparam int TW = dppc_pkg::THR_W;
  localparam int KW = dppc_pkg::STALL_W;
  localparam int DW = dppc_pkg::DIFF_W;

  // config registers
  logic signed [PW-1:0] left_target_r, right_target_r;
  logic signed [GW-1:0] p_gain_r, i_gain_r, d_gain_r;
  logic        [TW-1:0] settle_thr_r;

  // tick state
  logic signed [SW-1:0] left_sum_r, left_sum_nxt, right_sum_r, right_sum_nxt;
  logic signed [PW-1:0] left_last_r, left_last_nxt, right_last_r, right_last_nxt;
  logic        [KW-1:0] stall_r, stall_nxt, stall_inc;

  // stage valids
  logic v0_r, v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;
  logic ld1;
  dppc_pkg::pipe_ctl_t ctl;

  // stage 0 payload
  logic signed [PW-1:0] lpos0_r, rpos0_r;
  logic                 restart0_r;

  // stage 1 payload
  logic signed [PW-1:0] lerr1_r, lerr1_nxt, rerr1_r, rerr1_nxt;
  logic signed [DW-1:0] ldiff1_r, ldiff1_nxt, rdiff1_r, rdiff1_nxt;
  logic                 brake1_r, brake1_nxt, brake2_r, brake3_r, brake4_r;

  logic signed [PW-1:0] lerr_raw, rerr_raw;
  logic signed [PW-1:0] lprev, rprev;
  logic                 same_err, stall_over;

  logic [dppc_pkg::DRIVE_W-1:0] left_drive, right_drive;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_target_r  <= '0;
      right_target_r <= '0;
      p_gain_r       <= '0;
      i_gain_r       <= '0;
      d_gain_r       <= '0;
      settle_thr_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dppc_pkg::CFG_LEFT_TARGET:  left_target_r  <= cfg_data;
        dppc_pkg::CFG_RIGHT_TARGET: right_target_r <= cfg_data;
        dppc_pkg::CFG_P_GAIN:       p_gain_r       <= cfg_data[GW-1:0];
        dppc_pkg::CFG_I_GAIN:       i_gain_r       <= cfg_data[GW-1:0];
        dppc_pkg::CFG_D_GAIN:       d_gain_r       <= cfg_data[GW-1:0];
        dppc_pkg::CFG_SETTLE_THR:   settle_thr_r   <= cfg_data[TW-1:0];
        default: ;
      endcase
    end
  end

  // per-stage hold: a stage loads when it is empty or its content moves on
  assign rdy4      = !v4_r || out_tready;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = !v0_r || rdy1;
  assign ld1       = rdy1 && v0_r;
  assign ctl.ld2   = rdy2 && v1_r;
  assign ctl.ld3   = rdy3 && v2_r;
  assign ctl.ld4   = rdy4 && v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (in_tready) v0_r <= in_tvalid;
      if (rdy1)      v1_r <= v0_r;
      if (rdy2)      v2_r <= v1_r;
      if (rdy3)      v3_r <= v2_r;
      if (rdy4)      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      lpos0_r    <= in_tdata[PW-1:0];
      rpos0_r    <= in_tdata[2*PW-1:PW];
      restart0_r <= in_tuser[0];
    end
  end

  // stage 1: errors, integrals, settle and stall decisions
  always_comb begin
    lerr_raw      = dppc_pkg::err_sat(left_target_r, lpos0_r);
    rerr_raw      = dppc_pkg::err_sat(right_target_r, rpos0_r);
    lerr1_nxt     = restart0_r ? '0 : lerr_raw;
    rerr1_nxt     = restart0_r ? '0 : rerr_raw;
    lprev         = restart0_r ? '0 : left_last_r;
    rprev         = restart0_r ? '0 : right_last_r;
    left_sum_nxt  = restart0_r ? '0 : dppc_pkg::sum_sat(left_sum_r, lerr_raw);
    right_sum_nxt = restart0_r ? '0 : dppc_pkg::sum_sat(right_sum_r, rerr_raw);

    same_err   = (lerr1_nxt == lprev) && (rerr1_nxt == rprev);
    stall_inc  = same_err ? stall_r + KW'(1) : '0;
    stall_over = stall_inc > KW'(STALL_LIMIT);
    stall_nxt  = stall_over ? '0 : stall_inc;

    brake1_nxt = stall_over ||
                 (!restart0_r && dppc_pkg::below_thr(lerr_raw, settle_thr_r)
                              && dppc_pkg::below_thr(rerr_raw, settle_thr_r));

    // previous errors hold across a braking tick
    left_last_nxt  = brake1_nxt ? lprev : lerr1_nxt;
    right_last_nxt = brake1_nxt ? rprev : rerr1_nxt;

    ldiff1_nxt = {lerr1_nxt[PW-1], lerr1_nxt} - {lprev[PW-1], lprev};
    rdiff1_nxt = {rerr1_nxt[PW-1], rerr1_nxt} - {rprev[PW-1], rprev};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_sum_r   <= '0;
      right_sum_r  <= '0;
      left_last_r  <= '0;
      right_last_r <= '0;
      stall_r      <= '0;
    end else if (ld1) begin
      left_sum_r   <= left_sum_nxt;
      right_sum_r  <= right_sum_nxt;
      left_last_r  <= left_last_nxt;
      right_last_r <= right_last_nxt;
      stall_r      <= stall_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      lerr1_r  <= lerr1_nxt;
      rerr1_r  <= rerr1_nxt;
      ldiff1_r <= ldiff1_nxt;
      rdiff1_r <= rdiff1_nxt;
      brake1_r <= brake1_nxt;
    end
    if (ctl.ld2) brake2_r <= brake1_r;
    if (ctl.ld3) brake3_r <= brake2_r;
    if (ctl.ld4) brake4_r <= brake3_r;
  end

  // the integral registers change only when stage 1 reloads, so they match stage 1
  dppc_pid_lane #(.DRIVE_LIMIT(DRIVE_LIMIT)) u_left (
    .clk     (clk),
    .ctl     (ctl),
    .err_i   (lerr1_r),
    .diff_i  (ldiff1_r),
    .sum_i   (left_sum_r),
    .p_gain  (p_gain_r),
    .i_gain  (i_gain_r),
    .d_gain  (d_gain_r),
    .brake_i (brake3_r),
    .drive_o (left_drive)
  );

  dppc_pid_lane #(.DRIVE_LIMIT(DRIVE_LIMIT)) u_right (
    .clk     (clk),
    .ctl     (ctl),
    .err_i   (rerr1_r),
    .diff_i  (rdiff1_r),
    .sum_i   (right_sum_r),
    .p_gain  (p_gain_r),
    .i_gain  (i_gain_r),
    .d_gain  (d_gain_r),
    .brake_i (brake3_r),
    .drive_o (right_drive)
  );

  assign out_tvalid = v4_r;
  assign out_tdata  = {2'b00, right_drive, left_drive};
  assign out_tuser  = {brake4_r, brake4_r};

endmodule
`default_nettype wire

/* rtl/dppc_checker.sv */
// Port-level checks for dual_pid_position_controller_core, attached by bind.
// Depends only on the top level's ports and its DRIVE_LIMIT parameter.
`default_nettype none
module dppc_checker #(
  parameter int DRIVE_LIMIT = 12000
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic [1:0]  out_tuser
);

  logic signed [14:0] left_drive, right_drive;
  assign left_drive  = out_tdata[14:0];
  assign right_drive = out_tdata[29:15];

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_brake_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0] && out_tdata == 32'd0)
    else $error("settled result without brake and zero drive");

  a_no_brake_unsettled: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[1] |-> !out_tuser[0])
    else $error("brake without settled");

  a_drive_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && DRIVE_LIMIT < 16384 |->
      left_drive <= 15'(DRIVE_LIMIT) && left_drive >= -15'(DRIVE_LIMIT) &&
      right_drive <= 15'(DRIVE_LIMIT) && right_drive >= -15'(DRIVE_LIMIT))
    else $error("drive outside limit");

endmodule

bind dual_pid_position_controller_core dppc_checker #(.DRIVE_LIMIT(DRIVE_LIMIT)) u_dppc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire

/* test/tb_dual_pid_position_controller_core.sv */
// Self-checking testbench for dual_pid_position_controller_core: directed ticks and random
// moves, checked against an in-bench predictor of the PID tick.
// Depends on dppc_pkg and the controller RTL only.
`default_nettype none
module tb_dual_pid_position_controller_core;

  localparam int DRIVE_LIMIT = 12000;
  localparam int STALL_LIMIT = 5;
  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_PCT    = 31;
  localparam int PHASE_ITEMS = 225;
  localparam logic [dppc_pkg::CFG_IDX_W-1:0] CFG_UNUSED_6 = 3'd6;
  localparam logic [dppc_pkg::CFG_IDX_W-1:0] CFG_UNUSED_7 = 3'd7;
  localparam longint ERR_MAX = 2147483647;
  localparam longint ERR_MIN = -ERR_MAX - 1;
  localparam longint SUM_MAX = (longint'(1) << 47) - 1;
  localparam longint SUM_MIN = -SUM_MAX - 1;

  typedef struct {
    logic signed [31:0] left_pos;
    logic signed [31:0] right_pos;
    logic               restart;
  } tick_req_t;

  typedef struct {
    logic signed [14:0] left_drive;
    logic signed [14:0] right_drive;
    logic               brake;
    logic               settled;
  } drive_res_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  wire logic            in_tready;
  logic [63:0]          in_tdata = '0;   // [31:0] left_position, [63:32] right_position
  logic [0:0]           in_tuser = '0;   // [0] restart
  wire logic            out_tvalid;
  logic                 out_tready = 1'b0;
  wire logic [31:0]     out_tdata;       // [14:0] left_drive, [29:15] right_drive
  wire logic [1:0]      out_tuser;       // [0] brake, [1] settled
  logic                 cfg_valid = 1'b0;
  wire logic            cfg_ready;
  logic [dppc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  // controller registers as the predictor sees them
  logic signed [31:0] tgt_l = '0, tgt_r = '0;
  logic signed [23:0] kp = '0, ki = '0, kd = '0;
  logic [15:0]        thr = '0;
  // tick state
  longint     acc_l = 0, acc_r = 0, prev_l = 0, prev_r = 0;
  logic [2:0] stall_cnt = '0;

  tick_req_t  tick_q[$];
  drive_res_t drive_q[$];
  tick_req_t  cur_req;
  bit         no_idle = 1'b0;
  int         mismatch_cnt = 0;
  int         queued = 0;
  int         cycle_cnt = 0;

  dual_pid_position_controller_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic longint clamp(input longint x, input longint lo, input longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  // exact Q8.16 PID sum, truncated toward zero, clamped
  function automatic logic signed [14:0] pid_drive(input longint err, input longint acc,
                                                   input longint prev);
    logic signed [79:0] e80, s80, d80, kp80, ki80, kd80, total;
    logic               neg;
    e80 = err;
    s80 = acc;
    d80 = err - prev;
    kp80 = kp;
    ki80 = ki;
    kd80 = kd;
    total = e80 * kp80 + s80 * ki80 + d80 * kd80;
    neg = total[79];
    if (neg) total = -total;
    total = total >>> 16;
    if (total > DRIVE_LIMIT) total = DRIVE_LIMIT;
    if (neg) total = -total;
    return total[14:0];
  endfunction

  function automatic drive_res_t control_tick(input tick_req_t req);
    longint     le, re, al, ar;
    logic       settle;
    drive_res_t r;
    le = clamp(longint'(tgt_l) - longint'(req.left_pos), ERR_MIN, ERR_MAX);
    re = clamp(longint'(tgt_r) - longint'(req.right_pos), ERR_MIN, ERR_MAX);
    // integral is updated before the restart check, then thrown away on restart
    acc_l = clamp(acc_l + le, SUM_MIN, SUM_MAX);
    acc_r = clamp(acc_r + re, SUM_MIN, SUM_MAX);
    if (req.restart) begin
      acc_l = 0;
      acc_r = 0;
      le = 0;
      re = 0;
      prev_l = 0;
      prev_r = 0;
      settle = 1'b0;
    end else begin
      al = le < 0 ? -le : le;
      ar = re < 0 ? -re : re;
      settle = al < longint'(thr) && ar < longint'(thr);
    end
    if (le == prev_l && re == prev_r) stall_cnt = stall_cnt + 3'd1;
    else stall_cnt = '0;
    if (stall_cnt > STALL_LIMIT) begin
      settle = 1'b1;
      stall_cnt = '0;
    end
    if (settle) begin
      r = '{left_drive: '0, right_drive: '0, brake: 1'b1, settled: 1'b1};
    end else begin
      r.left_drive = pid_drive(le, acc_l, prev_l);
      r.right_drive = pid_drive(re, acc_r, prev_r);
      r.brake = 1'b0;
      r.settled = 1'b0;
      prev_l = le;
      prev_r = re;
    end
    return r;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) drive_q.push_back(control_tick(cur_req));
      if (!in_tvalid || in_tready) begin
        if (tick_q.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
          cur_req = tick_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {cur_req.right_pos, cur_req.left_pos};
          in_tuser <= cur_req.restart;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    drive_res_t exp_r;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
      if (out_tvalid && out_tready) begin
        if (drive_q.size() == 0) begin
          $display("%0t: unexpected result tdata=%h tuser=%b", $time, out_tdata, out_tuser);
          mismatch_cnt++;
        end else begin
          exp_r = drive_q.pop_front();
          if (exp_r.left_drive !== $signed(out_tdata[14:0]) ||
              exp_r.right_drive !== $signed(out_tdata[29:15]) ||
              exp_r.brake !== out_tuser[0] || exp_r.settled !== out_tuser[1]) begin
            $display("%0t: left_drive expected %0d got %0d, right_drive expected %0d got %0d",
                     $time, exp_r.left_drive, $signed(out_tdata[14:0]),
                     exp_r.right_drive, $signed(out_tdata[29:15]));
            $display("%0t: brake expected %b got %b, settled expected %b got %b",
                     $time, exp_r.brake, out_tuser[0], exp_r.settled, out_tuser[1]);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("dual_pid_position_controller_core verification failed");
      $finish;
    end
  end

  task automatic cfg_write(input logic [dppc_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      dppc_pkg::CFG_LEFT_TARGET:  tgt_l = val;
      dppc_pkg::CFG_RIGHT_TARGET: tgt_r = val;
      dppc_pkg::CFG_P_GAIN:       kp = val[23:0];
      dppc_pkg::CFG_I_GAIN:       ki = val[23:0];
      dppc_pkg::CFG_D_GAIN:       kd = val[23:0];
      dppc_pkg::CFG_SETTLE_THR:   thr = val[15:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic program_regs(input logic [31:0] lt, input logic [31:0] rt,
                              input logic [31:0] p, input logic [31:0] i,
                              input logic [31:0] d, input logic [31:0] th);
    cfg_write(dppc_pkg::CFG_LEFT_TARGET, lt);
    cfg_write(dppc_pkg::CFG_RIGHT_TARGET, rt);
    cfg_write(dppc_pkg::CFG_P_GAIN, p);
    cfg_write(dppc_pkg::CFG_I_GAIN, i);
    cfg_write(dppc_pkg::CFG_D_GAIN, d);
    cfg_write(dppc_pkg::CFG_SETTLE_THR, th);
    @(negedge clk);
  endtask

  // sender holds off until every outstanding request has produced its result
  task automatic wait_drained();
    do @(negedge clk); while (tick_q.size() != 0 || in_tvalid || drive_q.size() != 0);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic push_tick(input logic [31:0] lp, input logic [31:0] rp, input logic rs);
    tick_req_t req;
    req.left_pos = lp;
    req.right_pos = rp;
    req.restart = rs;
    tick_q.push_back(req);
    queued++;
  endtask

  function automatic longint rand_signed(input int unsigned mag);
    return $urandom_range(0, 1) ? longint'($urandom_range(0, mag))
                                : -longint'($urandom_range(0, mag));
  endfunction

  function automatic logic [31:0] rand_target();
    case ($urandom_range(0, 3))
      0, 1: return 32'(rand_signed(100000));
      2: return $urandom;
      default: return $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 2000)
                                           : 32'h80000000 + $urandom_range(0, 2000);
    endcase
  endfunction

  function automatic logic [31:0] rand_gain();
    int w;
    w = $urandom_range(9, 24);
    if ($urandom_range(0, 2) == 0) return 32'(65536 + rand_signed(30000));
    return 32'(int'($urandom_range(0, (1 << w) - 1)) - (1 << (w - 1)));
  endfunction

  // restart, then a converging move with overshoot, holds and, when thr is nonzero, a settle at the end
  task automatic queue_move(input int len);
    longint      el, er;
    logic [31:0] lp, rp;
    int          k, reps;
    el = rand_signed(1 << $urandom_range(0, 20));
    er = rand_signed(1 << $urandom_range(0, 20));
    push_tick($urandom, $urandom, 1'b1);
    for (k = 0; k < len; k++) begin
      if (k >= len - 3 && thr != 0) begin
        el = rand_signed(thr - 1);
        er = rand_signed(thr - 1);
      end else if ($urandom_range(0, 9) != 0) begin
        el = el * (int'($urandom_range(0, 10)) - 3) / 8 + rand_signed(3);
        er = er * (int'($urandom_range(0, 10)) - 3) / 8 + rand_signed(3);
      end
      lp = tgt_l - 32'(el);
      rp = tgt_r - 32'(er);
      reps = ($urandom_range(0, 11) == 0) ? $urandom_range(6, 8) : 1;
      repeat (reps) push_tick(lp, rp, 1'b0);
    end
  endtask

  initial begin
    int phase, start;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // registers at their reset values
    push_tick(32'd5, -32'sd5, 1'b0);
    push_tick(32'd5, -32'sd5, 1'b0);
    wait_drained();

    program_regs(32'd1000, -32'sd1000, 32'd98304, 32'd256, -32'sd16384, 32'd20);
    push_tick(32'd0, 32'd0, 1'b1);
    push_tick(32'd0, 32'd0, 1'b0);
    push_tick(32'd500, -32'sd500, 1'b0);
    push_tick(32'd1300, -32'sd1300, 1'b0);
    push_tick(32'd990, -32'sd990, 1'b0);         // inside threshold
    push_tick(32'd1000, -32'sd1000, 1'b0);       // on target
    push_tick(32'h7fffffff, 32'h80000000, 1'b0);
    repeat (7) push_tick(32'd0, 32'd0, 1'b1);   // back-to-back restarts stall out
    repeat (7) push_tick(32'd700, -32'sd700, 1'b0);
    wait_drained();

    // extremes: error saturation both ways, widest threshold
    program_regs(32'h7fffffff, 32'h80000000, 32'h007fffff, 32'hff800000, 32'h007fffff,
                 32'd65535);
    push_tick(32'h80000000, 32'h7fffffff, 1'b0);
    push_tick(32'h7fffffff, 32'h80000000, 1'b0);
    push_tick(32'd0, 32'd0, 1'b0);
    push_tick(32'h80000000, 32'h7fffffff, 1'b1);
    wait_drained();
    cfg_write(CFG_UNUSED_6, $urandom);
    cfg_write(CFG_UNUSED_7, $urandom);
    @(negedge clk);
    repeat (3) push_tick($urandom, $urandom, 1'b0);
    wait_drained();

    for (phase = 0; phase < 8; phase++) begin
      program_regs(rand_target(), rand_target(), rand_gain(), rand_gain(), rand_gain(),
                   phase == 0 ? 32'd0 : phase == 1 ? 32'd65535 :
                   $urandom_range(0, 1) ? $urandom_range(0, 300) : $urandom_range(0, 65535));
      // last phase runs at full rate on both sides
      no_idle = (phase == 7);
      start = queued;
      while (queued - start < PHASE_ITEMS) begin
        if ($urandom_range(0, 6) == 0) begin
          repeat ($urandom_range(1, 10))
            push_tick($urandom, $urandom, $urandom_range(0, 7) == 0);
        end else begin
          queue_move($urandom_range(6, 40));
        end
        if ($urandom_range(0, 12) == 0) wait_drained();
      end
      wait_drained();
    end
    no_idle = 1'b0;

    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("dual_pid_position_controller_core verification clean");
    end else begin
      $display("dual_pid_position_controller_core verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
